/* rtl/rjb_pkg.sv */
package rjb_pkg;

    localparam int BUF_BYTES_DEF    = 4096;
    localparam int MAX_DATAGRAM_DEF = 1600;
    localparam int RTP_HDR_BYTES    = 12;
    localparam int MAX_GRANT        = 4095;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [11:0] PLAY_THR_RST   = 12'd3072;
    localparam logic [11:0] REFILL_THR_RST = 12'd1024;

    // input commands
    localparam logic [1:0] CMD_HEADER  = 2'd0;
    localparam logic [1:0] CMD_PAYLOAD = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;
    localparam logic [1:0] CMD_POP     = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_LEN   = 3'd1;
    localparam logic [2:0] ST_DUP       = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_NOT_READY = 3'd4;

    // configuration register indexes
    localparam logic CFG_PLAY_THR   = 1'b0;
    localparam logic CFG_REFILL_THR = 1'b1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] seq_num;
        logic [10:0] packet_length;
        logic [15:0] sample_word;
        logic [12:0] request_length;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic        seq_gap;
        logic [11:0] granted_bytes;
        logic [7:0]  data_byte;
        logic        data_valid;
        logic [11:0] fill_level;
        logic        playing;
    } t_out_word;

    typedef enum logic [2:0] {
        OP_HEADER_BAD,
        OP_HEADER,
        OP_PAYLOAD,
        OP_READ,
        OP_POP
    } t_op;

    // classified word handed from front to back
    typedef struct packed {
        t_op         op;
        logic [15:0] seq_num;
        logic [7:0]  first_byte;
        logic [7:0]  second_byte;
        logic [12:0] request_length;
    } t_qword;

endpackage

/* rtl/rjb_front.sv */
module rjb_front #(
    parameter int MAX_DATAGRAM = 1600
) (
    input  rjb_pkg::t_in_word i_in_word,
    output rjb_pkg::t_qword   o_q_word
);
    import rjb_pkg::*;

    logic bad_len;

    // length must be whole words, hold the fixed header, and fit a datagram
    assign bad_len = (i_in_word.packet_length[1:0] != 2'b00)
                  || (i_in_word.packet_length < 11'(RTP_HDR_BYTES))
                  || (int'(i_in_word.packet_length) > MAX_DATAGRAM);

    always_comb begin
        case (i_in_word.cmd)
            CMD_HEADER:  o_q_word.op = bad_len ? OP_HEADER_BAD : OP_HEADER;
            CMD_PAYLOAD: o_q_word.op = OP_PAYLOAD;
            CMD_READ:    o_q_word.op = OP_READ;
            default:     o_q_word.op = OP_POP;
        endcase
        o_q_word.seq_num        = i_in_word.seq_num;
        // halfword is swapped: low byte goes into the FIFO first
        o_q_word.first_byte     = i_in_word.sample_word[7:0];
        o_q_word.second_byte    = i_in_word.sample_word[15:8];
        o_q_word.request_length = i_in_word.request_length;
    end

endmodule

/* rtl/rjb_queue.sv */
module rjb_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  rjb_pkg::t_qword i_word,
    output logic            o_valid,
    input  logic            i_ready,
    output rjb_pkg::t_qword o_word
);
    import rjb_pkg::*;

    localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    t_qword           r_buf [QUEUE_DEPTH];
    logic [QPW-1:0]   r_wptr;
    logic [QPW-1:0]   r_rptr;
    logic [QPW:0]     r_count;
    logic             push;
    logic             pop;

    assign o_ready = (r_count != (QPW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_word  = r_buf[r_rptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == QPW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == QPW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wptr] <= i_word;
        end
    end

endmodule

/* rtl/rjb_back.sv */
module rjb_back #(
    parameter int BUF_BYTES = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_index,
    input  logic [11:0]        i_cfg_data,
    input  logic               i_q_valid,
    output logic               o_q_ready,
    input  rjb_pkg::t_qword    i_q_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rjb_pkg::t_out_word o_out_word
);
    import rjb_pkg::*;

    localparam int IW = $clog2(BUF_BYTES);
    localparam int CW = (IW > 13) ? IW : 13;
    localparam logic [IW:0]   BUF_SIZE = (IW+1)'(BUF_BYTES);
    localparam logic [IW-1:0] LAST_IDX = IW'(BUF_BYTES - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_HI   = 3'b010,
        S_RD   = 3'b100
    } t_state;

    function automatic logic [IW-1:0] f_next(input logic [IW-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [IW-1:0] f_fill(input logic [IW-1:0] w, input logic [IW-1:0] r);
        logic [IW:0] wrapped;
        wrapped = BUF_SIZE - {1'b0, r} + {1'b0, w};
        return (w >= r) ? (w - r) : wrapped[IW-1:0];
    endfunction

    logic [7:0]    mem [BUF_BYTES];
    logic [7:0]    r_rdata;

    t_state        r_state, n_state;
    logic [IW-1:0] r_wr, n_wr;
    logic [IW-1:0] r_rd, n_rd;
    logic          r_playing, n_playing;
    logic [15:0]   r_last_seq, n_last_seq;
    logic          r_pkt_acc, n_pkt_acc;
    logic [11:0]   r_grant, n_grant;
    logic [7:0]    r_hi_byte, n_hi_byte;
    logic          r_lost, n_lost;
    logic [11:0]   r_play_thr;
    logic [11:0]   r_refill_thr;
    logic          r_out_valid;
    t_out_word     r_out_word;

    logic          out_free;
    logic          take;
    logic          full;
    logic          empty;
    logic          we;
    logic          re;
    logic [7:0]    wdata;
    logic          load;
    t_out_word     res;
    logic [CW-1:0] fill_x;
    logic [CW-1:0] req_x;
    logic [CW-1:0] min_x;
    logic [11:0]   grant_w;

    assign out_free  = !r_out_valid || i_out_ready;
    assign take      = (r_state == S_IDLE) && i_q_valid && out_free;
    assign o_q_ready = take;
    assign full      = (f_next(r_wr) == r_rd);
    assign empty     = (r_wr == r_rd);

    assign fill_x  = CW'(f_fill(r_wr, r_rd));
    assign req_x   = CW'(i_q_word.request_length);
    assign min_x   = (fill_x < req_x) ? fill_x : req_x;
    assign grant_w = (min_x > CW'(MAX_GRANT)) ? 12'(MAX_GRANT) & 12'hffc
                                              : {min_x[11:2], 2'b00};

    always_comb begin
        n_state    = r_state;
        n_wr       = r_wr;
        n_rd       = r_rd;
        n_playing  = r_playing;
        n_last_seq = r_last_seq;
        n_pkt_acc  = r_pkt_acc;
        n_grant    = r_grant;
        n_hi_byte  = r_hi_byte;
        n_lost     = r_lost;
        we         = 1'b0;
        re         = 1'b0;
        wdata      = i_q_word.first_byte;
        load       = 1'b0;
        res        = '0;
        case (r_state)
            S_IDLE: begin
                if (take) begin
                    case (i_q_word.op)
                        OP_HEADER_BAD: begin
                            res.status = ST_BAD_LEN;
                            n_pkt_acc  = 1'b0;
                            load       = 1'b1;
                        end
                        OP_HEADER: begin
                            if (i_q_word.seq_num == r_last_seq) begin
                                res.status = ST_DUP;
                                n_pkt_acc  = 1'b0;
                            end else begin
                                res.seq_gap = (i_q_word.seq_num != r_last_seq + 16'd1);
                                n_last_seq  = i_q_word.seq_num;
                                n_pkt_acc   = 1'b1;
                            end
                            load = 1'b1;
                        end
                        OP_PAYLOAD: begin
                            if (!r_pkt_acc) begin
                                load = 1'b1;
                            end else begin
                                // low byte now, high byte next cycle
                                if (!full) begin
                                    we   = 1'b1;
                                    n_wr = f_next(r_wr);
                                end
                                n_lost    = full;
                                n_hi_byte = i_q_word.second_byte;
                                n_state   = S_HI;
                            end
                        end
                        OP_READ: begin
                            if (r_playing) begin
                                if (fill_x < CW'(r_refill_thr)) begin
                                    n_playing  = 1'b0;
                                    res.status = ST_NOT_READY;
                                    n_grant    = '0;
                                end else begin
                                    res.granted_bytes = grant_w;
                                    n_grant           = grant_w;
                                end
                            end else if (fill_x >= CW'(r_play_thr)) begin
                                n_playing         = 1'b1;
                                res.granted_bytes = grant_w;
                                n_grant           = grant_w;
                            end else begin
                                res.status = ST_NOT_READY;
                                n_grant    = '0;
                            end
                            load = 1'b1;
                        end
                        OP_POP: begin
                            if (r_grant != '0 && !empty) begin
                                re      = 1'b1;
                                n_rd    = f_next(r_rd);
                                n_grant = r_grant - 12'd1;
                                n_state = S_RD;
                            end else begin
                                res.status = ST_NOT_READY;
                                load       = 1'b1;
                            end
                        end
                        default: begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            S_HI: begin
                wdata = r_hi_byte;
                if (!full) begin
                    we   = 1'b1;
                    n_wr = f_next(r_wr);
                end
                res.status = (r_lost || full) ? ST_FULL : ST_OK;
                load       = 1'b1;
                n_state    = S_IDLE;
            end
            S_RD: begin
                res.data_byte  = r_rdata;
                res.data_valid = 1'b1;
                load           = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        res.fill_level = 12'(f_fill(n_wr, n_rd));
        res.playing    = n_playing;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[r_wr] <= wdata;
        end
        if (re) begin
            r_rdata <= mem[r_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_wr         <= '0;
            r_rd         <= '0;
            r_playing    <= 1'b0;
            r_last_seq   <= '0;
            r_pkt_acc    <= 1'b0;
            r_grant      <= '0;
            r_lost       <= 1'b0;
            r_play_thr   <= PLAY_THR_RST;
            r_refill_thr <= REFILL_THR_RST;
            r_out_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_wr       <= n_wr;
            r_rd       <= n_rd;
            r_playing  <= n_playing;
            r_last_seq <= n_last_seq;
            r_pkt_acc  <= n_pkt_acc;
            r_grant    <= n_grant;
            r_lost     <= n_lost;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_PLAY_THR:   r_play_thr   <= i_cfg_data;
                    CFG_REFILL_THR: r_refill_thr <= i_cfg_data;
                    default: ;
                endcase
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi_byte <= n_hi_byte;
        if (load) begin
            r_out_word <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

/* rtl/rtp_audio_jitter_buffer_top.sv */
// channel   dir  handshake                  payload
// in        in   i_in_valid / o_in_ready    i_in_word  (t_in_word)
// out       out  o_out_valid / i_out_ready  o_out_word (t_out_word)
// cfg       in   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Words enter a two-deep queue; the back end takes one word at a time.
// Header, read request, refused pop: result loaded from S_IDLE. Payload halfword: low
// then high byte via S_HI (one FIFO write port). Granted pop: S_RD (registered read).
// Sync active-low reset clears pointers, mode and grant; FIFO contents stay undefined.
// The back end holds while the output register is full and not taken; input keeps
// flowing until the queue fills.
module rtp_audio_jitter_buffer_top #(
    parameter int BUF_BYTES    = rjb_pkg::BUF_BYTES_DEF,
    parameter int MAX_DATAGRAM = rjb_pkg::MAX_DATAGRAM_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rjb_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rjb_pkg::t_out_word o_out_word,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [11:0]        i_cfg_data
);
    import rjb_pkg::*;

    t_qword front_word;
    t_qword q_word;
    logic   q_valid;
    logic   q_ready;

    assign o_cfg_ready = 1'b1;

    rjb_front #(
        .MAX_DATAGRAM(MAX_DATAGRAM)
    ) u_front (
        .i_in_word(i_in_word),
        .o_q_word (front_word)
    );

    rjb_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_in_valid),
        .o_ready(o_in_ready),
        .i_word (front_word),
        .o_valid(q_valid),
        .i_ready(q_ready),
        .o_word (q_word)
    );

    rjb_back #(
        .BUF_BYTES(BUF_BYTES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_q_valid  (q_valid),
        .o_q_ready  (q_ready),
        .i_q_word   (q_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word)
    );

endmodule
